// ===== rtl/core/mcst_pkg.sv =====
package mcst_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);

  localparam logic [3:0] CMD_TICK   = 4'd0;
  localparam logic [3:0] CMD_CREATE = 4'd1;
  localparam logic [3:0] CMD_START  = 4'd2;
  localparam logic [3:0] CMD_STOP   = 4'd3;
  localparam logic [3:0] CMD_PAUSE  = 4'd4;
  localparam logic [3:0] CMD_RESUME = 4'd5;
  localparam logic [3:0] CMD_RESET  = 4'd6;
  localparam logic [3:0] CMD_DELETE = 4'd7;
  localparam logic [3:0] CMD_SETIVL = 4'd8;
  localparam logic [3:0] CMD_QUERY  = 4'd9;

  localparam logic [2:0] ST_FREE    = 3'd0;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_PAUSED  = 3'd3;
  localparam logic [2:0] ST_EXPIRED = 3'd4;

  localparam logic [1:0] MODE_ONESHOT  = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_WATCHDOG = 2'd2;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic apply;
    logic step;
    logic push;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic hit;
    logic need_push;
    logic out_free;
    logic idx_last;
    logic held_v;
  } ctl_sts_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  result_id;
    logic        ok;
    logic [2:0]  timer_state;
    logic        has_expired;
    logic [31:0] remaining_ms;
    logic [31:0] elapsed_ms;
    logic [31:0] trigger_count;
    logic [3:0]  active_count;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/mcst_req_if.sv =====
interface mcst_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [7:0]  timer_id;
  logic [1:0]  timer_mode;
  logic [31:0] interval_ms;

  modport source (output valid, command, timer_id, timer_mode, interval_ms, input ready);
  modport sink (input valid, command, timer_id, timer_mode, interval_ms, output ready);
endinterface

// ===== rtl/core/mcst_rsp_if.sv =====
interface mcst_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  result_id;
  logic        ok;
  logic [2:0]  timer_state;
  logic        has_expired;
  logic [31:0] remaining_ms;
  logic [31:0] elapsed_ms;
  logic [31:0] trigger_count;
  logic [3:0]  active_count;
  logic        last;

  modport source (output valid, result_kind, result_id, ok, timer_state, has_expired,
                  remaining_ms, elapsed_ms, trigger_count, active_count, last,
                  input ready);
  modport sink (input valid, result_kind, result_id, ok, timer_state, has_expired,
                remaining_ms, elapsed_ms, trigger_count, active_count, last,
                output ready);
endinterface

// ===== rtl/core/multi_channel_soft_timer.sv =====
// Table of timer slots in one-shot, periodic or watchdog mode. Each input
// transfer is a command; a tick advances the millisecond counter and walks
// the slots, giving one event transfer per expiring slot (at most eight,
// the final one marked last), other commands give exactly one reply. The
// slot walk visits each slot with a registered read of the slot memory,
// then the update, and it waits while the result side holds off a pending
// result. A new command is taken only once the last one is done.
// Lookups stop at the first matching slot.
module multi_channel_soft_timer (
  input logic         clk,
  input logic         rst,
  mcst_req_if.sink    req,
  mcst_rsp_if.source  rsp
);
  import mcst_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  result_t  res;

  mcst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcst_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (req.command),
    .in_id      (req.timer_id),
    .in_mode    (req.timer_mode),
    .in_ivl     (req.interval_ms),
    .res        (res),
    .res_valid  (rsp.valid),
    .res_ready  (rsp.ready)
  );

  assign rsp.result_kind   = res.result_kind;
  assign rsp.result_id     = res.result_id;
  assign rsp.ok            = res.ok;
  assign rsp.timer_state   = res.timer_state;
  assign rsp.has_expired   = res.has_expired;
  assign rsp.remaining_ms  = res.remaining_ms;
  assign rsp.elapsed_ms    = res.elapsed_ms;
  assign rsp.trigger_count = res.trigger_count;
  assign rsp.active_count  = res.active_count;
  assign rsp.last          = res.last;

  // A command is worked on alone: no second transfer right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("input accepted while a command is in progress");

  // Expiry events always report success.
  a_event_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.result_kind == KIND_EVENT |-> rsp.ok)
    else $error("expiry event without ok");

  // A stalled push never happens: the controller waits for a free output.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.push || cmd.flush |-> sts.out_free)
    else $error("result overwritten before transfer");

endmodule

// ===== rtl/core/mcst_ctrl.sv =====
module mcst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcst_pkg::ctl_sts_t  sts,
  output mcst_pkg::ctl_cmd_t  cmd
);
  import mcst_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        if (!(sts.need_push && !sts.out_free)) begin
          if ((!sts.is_tick && sts.hit) || sts.idx_last) state_next = S_FLUSH;
          else state_next = S_READ;
        end
      end
      S_FLUSH: begin
        if (!sts.held_v || sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_READ: cmd.rd = 1'b1;
      S_EVAL: begin
        if (!(sts.need_push && !sts.out_free)) begin
          cmd.apply = 1'b1;
          cmd.push  = sts.need_push;
          cmd.step  = !((!sts.is_tick && sts.hit) || sts.idx_last);
        end
      end
      S_FLUSH: cmd.flush = sts.held_v && sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/mcst_dp.sv =====
module mcst_dp (
  input  logic                clk,
  input  logic                rst,
  input  mcst_pkg::ctl_cmd_t  cmd,
  output mcst_pkg::ctl_sts_t  sts,
  input  logic [3:0]          in_command,
  input  logic [7:0]          in_id,
  input  logic [1:0]          in_mode,
  input  logic [31:0]         in_ivl,
  output mcst_pkg::result_t   res,
  output logic                res_valid,
  input  logic                res_ready
);
  import mcst_pkg::*;

  logic [3:0]       op;
  logic [7:0]       rid;
  logic [1:0]       rmode;
  logic [31:0]      rivl;
  logic [31:0]      now;
  logic [7:0]       next_id;
  logic [CNT_W-1:0] alloc;
  logic [IDX_W-1:0] idx;
  logic [3:0]       n;

  logic [7:0] slot_id   [NUM_SLOTS];
  logic [2:0] slot_st   [NUM_SLOTS];
  logic [1:0] slot_mode [NUM_SLOTS];

  logic [31:0] mem_ivl   [NUM_SLOTS];
  logic [31:0] mem_start [NUM_SLOTS];
  logic [31:0] mem_rem   [NUM_SLOTS];
  logic [31:0] mem_fire  [NUM_SLOTS];
  logic [31:0] rd_ivl, rd_start, rd_rem, rd_fire;

  result_t held;
  logic    held_v;
  result_t held_out;
  result_t out_r;
  logic    out_v;

  logic [2:0]  cur_st;
  logic [7:0]  cur_id;
  logic [1:0]  cur_mode;
  logic [31:0] el, left;
  logic        el_done, is_tick, running, fire, hit, idx_last, out_free;

  // Write controls for the slots and for the allocation and id counters.
  logic             we_ivl, we_start, we_rem, we_fire, we_st, we_idmode, we_alloc, we_nid;
  logic [31:0]      wd_ivl, wd_start, wd_rem, wd_fire;
  logic [2:0]       wd_st;
  logic [7:0]       wd_id, nid_inc;
  logic [1:0]       wd_mode;
  logic [CNT_W-1:0] wd_alloc;
  logic             build;
  result_t          built;

  assign cur_st   = slot_st[idx];
  assign cur_id   = slot_id[idx];
  assign cur_mode = slot_mode[idx];
  assign el       = now - rd_start;
  assign el_done  = el >= rd_ivl;
  assign left     = el_done ? 32'd0 : rd_ivl - el;
  assign is_tick  = op == CMD_TICK;
  assign running  = cur_st == ST_RUNNING;
  assign fire     = is_tick && running && el_done;
  assign idx_last = idx == IDX_W'(NUM_SLOTS - 1);
  assign out_free = !out_v || res_ready;
  assign nid_inc  = (next_id == 8'd255) ? 8'd1 : next_id + 8'd1;

  always_comb begin
    if (op == CMD_CREATE) hit = cur_st == ST_FREE && rmode <= MODE_WATCHDOG;
    else hit = cur_st != ST_FREE && cur_id == rid;
  end

  assign sts.is_tick   = is_tick;
  assign sts.hit       = hit;
  assign sts.need_push = fire && n < 4'(MAX_RESULTS) && held_v;
  assign sts.out_free  = out_free;
  assign sts.idx_last  = idx_last;
  assign sts.held_v    = held_v;

  always_comb begin
    we_ivl = 1'b0; we_start = 1'b0; we_rem = 1'b0; we_fire = 1'b0;
    we_st = 1'b0; we_idmode = 1'b0; we_alloc = 1'b0; we_nid = 1'b0;
    wd_ivl = rd_ivl; wd_start = now; wd_rem = rd_ivl; wd_fire = rd_fire + 32'd1;
    wd_st = cur_st; wd_id = next_id; wd_mode = rmode; wd_alloc = alloc;
    build = 1'b0;
    built = '0;
    built.result_kind  = KIND_REPLY;
    built.result_id    = rid;
    built.active_count = 4'(alloc);
    if (is_tick) begin
      if (running) begin
        if (el_done) begin
          we_fire = 1'b1;
          if (cur_mode == MODE_PERIODIC) begin
            we_start = 1'b1;
            we_rem   = 1'b1;
          end else begin
            we_st = 1'b1;
            wd_st = ST_EXPIRED;
          end
          build               = n < 4'(MAX_RESULTS);
          built.result_kind   = KIND_EVENT;
          built.result_id     = cur_id;
          built.ok            = 1'b1;
          built.timer_state   = wd_st;
          built.has_expired   = wd_st == ST_EXPIRED;
          built.trigger_count = wd_fire;
        end else begin
          we_rem = 1'b1;
          wd_rem = rd_ivl - el;
        end
      end
    end else if (hit) begin
      build = 1'b1;
      case (op)
        CMD_CREATE: begin
          we_idmode = 1'b1; we_st = 1'b1; wd_st = ST_CREATED;
          we_ivl = 1'b1; wd_ivl = rivl;
          we_start = 1'b1; wd_start = 32'd0;
          we_rem = 1'b1; wd_rem = rivl;
          we_fire = 1'b1; wd_fire = 32'd0;
          we_alloc = 1'b1; wd_alloc = alloc + CNT_W'(1);
          we_nid = 1'b1;
          built.result_id = next_id;
          built.ok        = 1'b1;
        end
        CMD_START, CMD_RESET: begin
          we_start = 1'b1; we_rem = 1'b1;
          we_st = 1'b1; wd_st = ST_RUNNING;
          built.ok = 1'b1;
        end
        CMD_STOP: begin
          we_st = 1'b1; wd_st = ST_FREE;
          we_alloc = 1'b1; wd_alloc = alloc - CNT_W'(1);
          built.ok = 1'b1;
        end
        CMD_PAUSE: begin
          if (running) begin
            we_rem = 1'b1; wd_rem = left;
            we_st = 1'b1; wd_st = ST_PAUSED;
            built.ok = 1'b1;
          end
        end
        CMD_RESUME: begin
          if (cur_st == ST_PAUSED) begin
            we_ivl = 1'b1; wd_ivl = rd_rem;
            we_start = 1'b1;
            we_st = 1'b1; wd_st = ST_RUNNING;
            built.ok = 1'b1;
          end
        end
        CMD_DELETE: begin
          we_idmode = 1'b1; wd_id = 8'd0; wd_mode = MODE_ONESHOT;
          we_st = 1'b1; wd_st = ST_FREE;
          we_alloc = 1'b1; wd_alloc = alloc - CNT_W'(1);
          built.ok = 1'b1;
        end
        CMD_SETIVL: begin
          we_ivl = 1'b1; wd_ivl = rivl;
          built.ok = 1'b1;
        end
        CMD_QUERY: begin
          built.ok            = 1'b1;
          built.timer_state   = cur_st;
          built.has_expired   = cur_st == ST_EXPIRED;
          built.remaining_ms  = running ? left : rd_rem;
          built.elapsed_ms    = running ? el : 32'd0;
          built.trigger_count = rd_fire;
        end
        default: ;
      endcase
      built.active_count = 4'(wd_alloc);
    end else if (idx_last) begin
      // No slot matched: a failed create reports id zero, a failed query
      // reports the timer as gone.
      build = 1'b1;
      if (op == CMD_CREATE) built.result_id = 8'd0;
      if (op == CMD_QUERY) built.has_expired = 1'b1;
    end
  end

  // The held result goes out marked last only when the walk is done.
  always_comb begin
    held_out      = held;
    held_out.last = cmd.flush;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_ivl   <= mem_ivl[idx];
      rd_start <= mem_start[idx];
      rd_rem   <= mem_rem[idx];
      rd_fire  <= mem_fire[idx];
    end
    if (cmd.apply) begin
      if (we_ivl) mem_ivl[idx] <= wd_ivl;
      if (we_start) mem_start[idx] <= wd_start;
      if (we_rem) mem_rem[idx] <= wd_rem;
      if (we_fire) mem_fire[idx] <= wd_fire;
      if (we_idmode) begin
        slot_id[idx]   <= wd_id;
        slot_mode[idx] <= wd_mode;
      end
    end
    if (cmd.start) begin
      op    <= in_command;
      rid   <= in_id;
      rmode <= in_mode;
      rivl  <= in_ivl;
    end
    if (cmd.apply && build) held <= built;
    if (cmd.push || cmd.flush) out_r <= held_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now     <= '0;
      next_id <= 8'd1;
      alloc   <= '0;
      idx     <= '0;
      n       <= '0;
      held_v  <= 1'b0;
      out_v   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_st[i] <= ST_FREE;
    end else begin
      if (cmd.start) begin
        if (in_command == CMD_TICK) now <= now + 32'd1;
        idx    <= '0;
        n      <= '0;
        held_v <= 1'b0;
      end
      if (cmd.step) idx <= idx + IDX_W'(1);
      if (cmd.apply) begin
        if (we_st) slot_st[idx] <= wd_st;
        if (we_alloc) alloc <= wd_alloc;
        if (we_nid) next_id <= nid_inc;
        if (build) begin
          held_v <= 1'b1;
          if (is_tick) n <= n + 4'd1;
        end
      end
      if (cmd.flush) held_v <= 1'b0;
      if (cmd.push || cmd.flush) out_v <= 1'b1;
      else if (res_ready) out_v <= 1'b0;
    end
  end

  assign res       = out_r;
  assign res_valid = out_v;

endmodule
